### design/two_level_lru_hot_data_identifier_defines.svh
// ----------------------------------------------------------------------------
// Two-level LRU hot data identifier: assertion macros
// Immediate-implication and next-cycle checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_LRU_HOT_DATA_IDENTIFIER_DEFINES_SVH
`define TWO_LEVEL_LRU_HOT_DATA_IDENTIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define TLHD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlhd check failed");
`define TLHD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlhd check failed");
`else
`define TLHD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TLHD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/tlhd_pkg.sv
// ----------------------------------------------------------------------------
// tlhd_pkg
// Shared types and constants of the two-level LRU hot data identifier.
// ----------------------------------------------------------------------------
package tlhd_pkg;

    localparam int HOT_DEPTH_DEF  = 64;
    localparam int COOL_DEPTH_DEF = 64;
    localparam int PAGE_BITS_DEF  = 32;

    localparam int PAGE_W    = 32;
    localparam int LIMIT_W   = 7;
    localparam int OUTCOME_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [OUTCOME_W-1:0] OUT_HOT_HIT  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_PROMOTED = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_COLD     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HOT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_LIMIT = 2'd1;

    // list operation applied in the update cycle
    typedef enum logic [1:0] {
        LC_NONE,
        LC_MOVE,    // hit entry to front, entries ahead of it step back
        LC_REMOVE,  // hit entry leaves, entries behind it step forward
        LC_PUSH     // new entry at front, all step back, tail trimmed to limit
    } t_list_cmd;

    typedef struct packed {
        logic take_left;
        logic take_right;
        logic lim_ok;
    } t_cell_ctl;

endpackage

### design/tlhd_cell.sv
// ----------------------------------------------------------------------------
// tlhd_cell
// One list slot: holds a page and its valid bit, compares against the key
// and takes its neighbour's contents when the list shifts.
// ----------------------------------------------------------------------------
module tlhd_cell #(
    parameter int PAGE_BITS = tlhd_pkg::PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PAGE_BITS-1:0] i_key,
    input  tlhd_pkg::t_cell_ctl  i_ctl,
    input  logic [PAGE_BITS-1:0] i_left_page,
    input  logic                 i_left_valid,
    input  logic [PAGE_BITS-1:0] i_right_page,
    input  logic                 i_right_valid,
    output logic [PAGE_BITS-1:0] o_page,
    output logic                 o_valid,
    output logic                 o_match
);
    import tlhd_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] n_page;
    logic                 r_valid;
    logic                 n_valid;

    always_comb begin
        n_page  = r_page;
        n_valid = r_valid;
        if (i_ctl.take_left) begin
            n_page  = i_left_page;
            n_valid = i_left_valid & i_ctl.lim_ok;
        end else if (i_ctl.take_right) begin
            n_page  = i_right_page;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

    assign o_page  = r_page;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_page == i_key);

endmodule

### design/tlhd_list.sv
// ----------------------------------------------------------------------------
// tlhd_list
// Recency list as a row of cells, front at cell 0. Match vector is
// registered each cycle; the command then shifts the row in one step.
// ----------------------------------------------------------------------------
`include "two_level_lru_hot_data_identifier_defines.svh"

module tlhd_list #(
    parameter int DEPTH     = tlhd_pkg::HOT_DEPTH_DEF,
    parameter int PAGE_BITS = tlhd_pkg::PAGE_BITS_DEF,
    parameter int LIM_W     = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PAGE_BITS-1:0] i_key,
    input  tlhd_pkg::t_list_cmd  i_cmd,
    input  logic [LIM_W-1:0]     i_limit,
    output logic                 o_hit
);
    import tlhd_pkg::*;

    logic [PAGE_BITS-1:0] w_page  [DEPTH];
    logic [DEPTH-1:0]     w_valid;
    logic [DEPTH-1:0]     w_match;
    logic [DEPTH-1:0]     r_match;
    logic                 r_hit;
    logic [DEPTH-1:0]     w_sel_up;
    logic [DEPTH-1:0]     w_sel_down;

    // one-hot match at index h: up covers 0..h, down covers h..end
    assign w_sel_up   = r_match | (r_match - DEPTH'(1));
    assign w_sel_down = ~(r_match - DEPTH'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_match <= w_match;
            r_hit   <= |w_match;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic [PAGE_BITS-1:0] w_lp;
            logic                 w_lv;
            logic [PAGE_BITS-1:0] w_rp;
            logic                 w_rv;
            t_cell_ctl            w_ctl;

            always_comb begin
                w_ctl = '0;
                case (i_cmd)
                    LC_MOVE: begin
                        w_ctl.take_left = w_sel_up[k];
                        w_ctl.lim_ok    = 1'b1;
                    end
                    LC_REMOVE: begin
                        w_ctl.take_right = w_sel_down[k];
                    end
                    LC_PUSH: begin
                        w_ctl.take_left = 1'b1;
                        w_ctl.lim_ok    = (LIM_W'(k) < i_limit);
                    end
                    default: begin
                        w_ctl = '0;
                    end
                endcase
            end

            if (k == 0) begin : g_front
                assign w_lp = i_key;
                assign w_lv = 1'b1;
            end else begin : g_mid
                assign w_lp = w_page[k-1];
                assign w_lv = w_valid[k-1];
            end

            if (k == DEPTH - 1) begin : g_tail
                assign w_rp = '0;
                assign w_rv = 1'b0;
            end else begin : g_inner
                assign w_rp = w_page[k+1];
                assign w_rv = w_valid[k+1];
            end

            tlhd_cell #(
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_key         (i_key),
                .i_ctl         (w_ctl),
                .i_left_page   (w_lp),
                .i_left_valid  (w_lv),
                .i_right_page  (w_rp),
                .i_right_valid (w_rv),
                .o_page        (w_page[k]),
                .o_valid       (w_valid[k]),
                .o_match       (w_match[k])
            );
        end
    endgenerate

    assign o_hit = r_hit;

    // pages are unique within a list
    `TLHD_ASSERT_IMP(a_match_unique, i_clk, i_rst_n, 1'b1, $onehot0(r_match))
    // valid entries always form an unbroken run from the front
    `TLHD_ASSERT_IMP(a_valid_prefix, i_clk, i_rst_n, 1'b1,
        $onehot({1'b0, w_valid} + (DEPTH + 1)'(1)))
    `TLHD_ASSERT_NXT(a_push_front, i_clk, i_rst_n, i_cmd == LC_PUSH, w_valid[0])

endmodule

### design/two_level_lru_hot_data_identifier.sv
// ----------------------------------------------------------------------------
// two_level_lru_hot_data_identifier
// Classifies pages of writes and queries as hot or cold using a hot list and a cooldown
// list, each a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Channel  Handshake                 Payload
// in       i_in_valid / o_in_ready   i_op, i_page
// out      o_out_valid / i_out_ready o_hot, o_outcome
// cfg      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// The lookup state registers the match vectors of all cells; the update state shifts
// the cells and loads the result register; items follow back to back.
// The update cycle waits while a previous result is still held on the output.
// Both lists are empty from reset (valid bits cleared at once, no sweep).
// Configuration port is always ready.
// ----------------------------------------------------------------------------
`include "two_level_lru_hot_data_identifier_defines.svh"

module two_level_lru_hot_data_identifier #(
    parameter int HOT_DEPTH  = tlhd_pkg::HOT_DEPTH_DEF,
    parameter int COOL_DEPTH = tlhd_pkg::COOL_DEPTH_DEF,
    parameter int PAGE_BITS  = tlhd_pkg::PAGE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic [tlhd_pkg::PAGE_W-1:0]        i_page,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_hot,
    output logic [tlhd_pkg::OUTCOME_W-1:0]     o_outcome,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tlhd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tlhd_pkg::LIMIT_W-1:0]       i_cfg_data
);
    import tlhd_pkg::*;

    localparam int HL_W = $clog2(HOT_DEPTH + 1);
    localparam int CL_W = $clog2(COOL_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    t_state                r_state;
    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_op;
    logic                  r_out_valid;
    logic                  r_hot;
    logic [OUTCOME_W-1:0]  r_outcome;
    logic [LIMIT_W-1:0]    r_hot_limit;
    logic [LIMIT_W-1:0]    r_cool_limit;

    logic [PAGE_BITS-1:0]  w_key;
    logic                  w_done;
    logic                  w_in_acc;
    logic                  w_hot_hit;
    logic                  w_cool_hit;
    logic [HL_W-1:0]       w_hot_lim;
    logic [CL_W-1:0]       w_cool_lim;
    t_list_cmd             w_hot_cmd;
    t_list_cmd             w_cool_cmd;
    logic                  w_res_hot;
    logic [OUTCOME_W-1:0]  w_res_outcome;

    assign w_key      = PAGE_BITS'({{PAGE_BITS{1'b0}}, i_page});
    assign w_done     = (r_state == ST_UPDATE) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == ST_IDLE) || w_done;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // zero limit acts as one, anything above the depth saturates
    always_comb begin
        if (r_hot_limit == '0) begin
            w_hot_lim = HL_W'(1);
        end else if (32'(r_hot_limit) > HOT_DEPTH) begin
            w_hot_lim = HL_W'(HOT_DEPTH);
        end else begin
            w_hot_lim = HL_W'(r_hot_limit);
        end
        if (r_cool_limit == '0) begin
            w_cool_lim = CL_W'(1);
        end else if (32'(r_cool_limit) > COOL_DEPTH) begin
            w_cool_lim = CL_W'(COOL_DEPTH);
        end else begin
            w_cool_lim = CL_W'(r_cool_limit);
        end
    end

    always_comb begin
        w_hot_cmd     = LC_NONE;
        w_cool_cmd    = LC_NONE;
        w_res_hot     = 1'b0;
        w_res_outcome = OUT_COLD;
        if (w_hot_hit) begin
            w_res_hot     = 1'b1;
            w_res_outcome = OUT_HOT_HIT;
            if (r_op == OP_WRITE) begin
                w_hot_cmd = LC_MOVE;
            end
        end else if (r_op == OP_WRITE) begin
            if (w_cool_hit) begin
                w_res_hot     = 1'b1;
                w_res_outcome = OUT_PROMOTED;
                w_hot_cmd     = LC_PUSH;
                w_cool_cmd    = LC_REMOVE;
            end else begin
                w_cool_cmd = LC_PUSH;
            end
        end
        if (!w_done) begin
            w_hot_cmd  = LC_NONE;
            w_cool_cmd = LC_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_state <= ST_LOOKUP;
            end else if (r_state == ST_LOOKUP) begin
                r_state <= ST_UPDATE;
            end else if (w_done) begin
                r_state <= ST_IDLE;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_acc) begin
            r_page <= w_key;
            r_op   <= i_op;
        end
        if (w_done) begin
            r_hot     <= w_res_hot;
            r_outcome <= w_res_outcome;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hot_limit  <= LIMIT_W'(64);
            r_cool_limit <= LIMIT_W'(64);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_HOT_LIMIT) begin
                r_hot_limit <= i_cfg_data;
            end else if (i_cfg_index == REG_COOL_LIMIT) begin
                r_cool_limit <= i_cfg_data;
            end
        end
    end

    tlhd_list #(
        .DEPTH     (HOT_DEPTH),
        .PAGE_BITS (PAGE_BITS),
        .LIM_W     (HL_W)
    ) u_hot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_page),
        .i_cmd   (w_hot_cmd),
        .i_limit (w_hot_lim),
        .o_hit   (w_hot_hit)
    );

    tlhd_list #(
        .DEPTH     (COOL_DEPTH),
        .PAGE_BITS (PAGE_BITS),
        .LIM_W     (CL_W)
    ) u_cool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_page),
        .i_cmd   (w_cool_cmd),
        .i_limit (w_cool_lim),
        .o_hit   (w_cool_hit)
    );

    assign o_out_valid = r_out_valid;
    assign o_hot       = r_hot;
    assign o_outcome   = r_outcome;
    assign o_cfg_ready = 1'b1;

    // a page never sits in both lists
    `TLHD_ASSERT_IMP(a_lists_disjoint, i_clk, i_rst_n, r_state == ST_UPDATE,
        !(w_hot_hit && w_cool_hit))
    `TLHD_ASSERT_IMP(a_result_from_update, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state == ST_UPDATE))
    `TLHD_ASSERT_NXT(a_lookup_one_cycle, i_clk, i_rst_n, r_state == ST_LOOKUP,
        r_state == ST_UPDATE)

endmodule
